// File: design/vuc_pkg.sv
package vuc_pkg;

  localparam int ROBOT_COUNT  = 64;
  localparam int CORDIC_STEPS = 17;
  localparam int SQRT_STEPS   = 16;
  // angle unit: magnitude/lzc stage, shift stage, CORDIC steps, quadrant fix
  localparam int ANG_LAT      = CORDIC_STEPS + 3;
  localparam int SQRT_PAD     = ANG_LAT - SQRT_STEPS - 1;

  localparam logic signed [19:0] ANG_PI      = 20'sd205887;
  localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;

  localparam logic [14:0] TURN_MAX_RST   = 15'd4915;
  localparam logic [12:0] SPEED_FLR_RST  = 13'd41;
  localparam logic [13:0] DEAD_BAND_RST  = 14'd410;

  localparam logic [1:0] REG_TURN_MAX  = 2'd0;
  localparam logic [1:0] REG_SPEED_FLR = 2'd1;
  localparam logic [1:0] REG_DEAD_BAND = 2'd2;

  typedef logic signed [33:0] arg_t;
  typedef logic signed [18:0] angle_t;

  typedef struct packed {
    logic both_zero;
    logic ax_zero;
    logic ay_zero;
    logic x_neg;
    logic y_neg;
  } quad_t;

  function automatic logic signed [19:0] atan_at(input logic [4:0] i);
    logic signed [19:0] a;
    unique case (i)
      5'd0:    a = 20'sd51472;
      5'd1:    a = 20'sd30386;
      5'd2:    a = 20'sd16055;
      5'd3:    a = 20'sd8150;
      5'd4:    a = 20'sd4091;
      5'd5:    a = 20'sd2047;
      5'd6:    a = 20'sd1024;
      5'd7:    a = 20'sd512;
      5'd8:    a = 20'sd256;
      5'd9:    a = 20'sd128;
      5'd10:   a = 20'sd64;
      5'd11:   a = 20'sd32;
      5'd12:   a = 20'sd16;
      5'd13:   a = 20'sd8;
      5'd14:   a = 20'sd4;
      5'd15:   a = 20'sd2;
      5'd16:   a = 20'sd1;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: design/velocity_to_unicycle_command_core.sv
// Throughput: one transaction per cycle unless the output stalls; set by the 17-step CORDIC pipeline
//   and the 16-digit square-root pipeline, one step per register stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous): all valid bits clear, registers take their
//   defaults (turn_rate_max 4915, speed_floor 41, heading_dead_band 410).
module velocity_to_unicycle_command_core
  import vuc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // robot_index[5:0], vel_x[21:6], vel_y[37:22], quat_x[53:38],
  // quat_y[69:54], quat_z[85:70], quat_w[101:86], zero pad[103:102]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // robot_id_out[5:0], forward_speed[21:6], turn_rate[37:22], zero pad[39:38]
  output logic [39:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef struct packed {
    logic [5:0] idx;
    logic       moving;
  } side_t;

  logic adv;

  logic [14:0] turn_max_r;
  logic [12:0] speed_flr_r;
  logic [13:0] dead_band_r;

  logic [5:0]  in_idx;
  logic signed [15:0] in_vx, in_vy, in_qx, in_qy, in_qz, in_qw;

  // stage 1: products
  logic        v1_r;
  logic [5:0]  idx1_r;
  logic signed [15:0] vx1_r, vy1_r;
  logic signed [31:0] pxx_r, pyy_r, pwz_r, pxy_r, pzz_r, pqy_r;

  // stage 2: sums
  logic        v2_r;
  side_t       s2_r;
  logic [31:0] sum_r;
  arg_t        num_r, den_r, hy_r, hx_r;

  logic        vld_r  [ANG_LAT];
  side_t       side_r [ANG_LAT];

  angle_t      yaw, head;
  logic [15:0] speed;

  logic signed [20:0] diff, band;
  logic signed [15:0] turn;
  logic [15:0] spd_f;

  logic        out_v_r;
  logic [39:0] out_d_r;

  // the whole pipeline moves unless the result at the output is held
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  assign in_idx = in_tdata[5:0];
  assign in_vx  = in_tdata[21:6];
  assign in_vy  = in_tdata[37:22];
  assign in_qx  = in_tdata[53:38];
  assign in_qy  = in_tdata[69:54];
  assign in_qz  = in_tdata[85:70];
  assign in_qw  = in_tdata[101:86];

  // configuration: writes on the access phase, zero-wait
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_max_r  <= TURN_MAX_RST;
      speed_flr_r <= SPEED_FLR_RST;
      dead_band_r <= DEAD_BAND_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_TURN_MAX:  turn_max_r  <= cfg_pwdata[14:0];
        REG_SPEED_FLR: speed_flr_r <= cfg_pwdata[12:0];
        REG_DEAD_BAND: dead_band_r <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_TURN_MAX:  cfg_prdata = 32'(turn_max_r);
      REG_SPEED_FLR: cfg_prdata = 32'(speed_flr_r);
      REG_DEAD_BAND: cfg_prdata = 32'(dead_band_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // valid bits; drop robots beyond the configured count at the door
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k < ANG_LAT; k++) vld_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid && (32'(in_idx) < ROBOT_COUNT);
      v2_r <= v1_r;
      vld_r[0] <= v2_r;
      for (int k = 1; k < ANG_LAT; k++) vld_r[k] <= vld_r[k-1];
      out_v_r <= vld_r[ANG_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= in_idx;
      vx1_r  <= in_vx;
      vy1_r  <= in_vy;
      pxx_r  <= in_vx * in_vx;
      pyy_r  <= in_vy * in_vy;
      pwz_r  <= in_qw * in_qz;
      pxy_r  <= in_qx * in_qy;
      pzz_r  <= in_qz * in_qz;
      pqy_r  <= in_qy * in_qy;

      s2_r   <= '{idx: idx1_r, moving: (vx1_r != '0) || (vy1_r != '0)};
      sum_r  <= pxx_r + pyy_r;
      num_r  <= (34'(pwz_r) + 34'(pxy_r)) <<< 1;
      den_r  <= (34'sd1 <<< 28) - ((34'(pzz_r) + 34'(pqy_r)) <<< 1);
      hy_r   <= 34'(vy1_r);
      hx_r   <= 34'(vx1_r);

      side_r[0] <= s2_r;
      for (int k = 1; k < ANG_LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  vuc_angle u_yaw (
    .clk   (clk),
    .en    (adv),
    .arg_y (num_r),
    .arg_x (den_r),
    .angle (yaw)
  );

  vuc_angle u_head (
    .clk   (clk),
    .en    (adv),
    .arg_y (hy_r),
    .arg_x (hx_r),
    .angle (head)
  );

  vuc_isqrt u_root (
    .clk      (clk),
    .en       (adv),
    .radicand (sum_r),
    .root     (speed)
  );

  // heading error against the dead band; short way round at +-pi
  always_comb begin
    diff = 21'(yaw) - 21'(head);
    band = 21'({dead_band_r, 4'b0000});
    if (!side_r[ANG_LAT-1].moving) turn = '0;
    else if (diff > band)
      turn = (diff < 21'(ANG_PI)) ? -16'(turn_max_r) : 16'(turn_max_r);
    else if (diff < -band)
      turn = (diff < -21'(ANG_PI)) ? -16'(turn_max_r) : 16'(turn_max_r);
    else turn = '0;
    spd_f = (!side_r[ANG_LAT-1].moving || speed < 16'(speed_flr_r)) ? 16'd0 : speed;
  end

  always_ff @(posedge clk) begin
    if (adv) out_d_r <= {2'b00, turn, spd_f, side_r[ANG_LAT-1].idx};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// File: design/vuc_angle.sv
module vuc_angle
  import vuc_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  arg_t   arg_y,
  input  arg_t   arg_x,
  output angle_t angle
);

  logic [32:0] ax_c, ay_c, m_c;
  logic [5:0]  msb_c;
  logic [32:0] ax_r, ay_r;
  logic [5:0]  msb_r;
  logic [30:0] nx_c, ny_c;
  quad_t       qa_r;
  quad_t       q_r [CORDIC_STEPS+1];
  logic signed [35:0] cx_r [CORDIC_STEPS+1];
  logic signed [35:0] cy_r [CORDIC_STEPS+1];
  logic signed [19:0] z_r  [CORDIC_STEPS+1];
  logic signed [19:0] zc, zf;
  angle_t angle_r;

  // magnitudes and leading-one position of the larger one
  always_comb begin
    ax_c = arg_x[33] ? 33'(-arg_x) : 33'(arg_x);
    ay_c = arg_y[33] ? 33'(-arg_y) : 33'(arg_y);
    m_c  = (ax_c > ay_c) ? ax_c : ay_c;
    msb_c = 6'd0;
    for (int k = 0; k < 33; k++) begin
      if (m_c[k]) msb_c = 6'(k);
    end
  end

  // normalise so the larger magnitude sits at bit 30
  always_comb begin
    if (msb_r > 6'd30) begin
      nx_c = 31'(ax_r >> (msb_r - 6'd30));
      ny_c = 31'(ay_r >> (msb_r - 6'd30));
    end else begin
      nx_c = 31'(ax_r << (6'd30 - msb_r));
      ny_c = 31'(ay_r << (6'd30 - msb_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= ax_c;
      ay_r  <= ay_c;
      msb_r <= msb_c;
      qa_r <= '{both_zero: (ax_c == '0) && (ay_c == '0), ax_zero: ax_c == '0,
                ay_zero: ay_c == '0, x_neg: arg_x[33], y_neg: arg_y[33]};
      cx_r[0] <= 36'(nx_c);
      cy_r[0] <= 36'(ny_c);
      z_r[0]  <= '0;
      q_r[0]  <= qa_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [35:0] dx, dy;
    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!cy_r[i][35]) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          z_r[i+1]  <= z_r[i] + atan_at(5'(i));
        end else begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          z_r[i+1]  <= z_r[i] - atan_at(5'(i));
        end
      end
    end
  end

  // clamp to the first quadrant, then fold into the right quadrant
  always_comb begin
    zc = z_r[CORDIC_STEPS];
    if (zc < 0) zc = '0;
    if (zc > ANG_HALF_PI) zc = ANG_HALF_PI;
    if (q_r[CORDIC_STEPS].ay_zero) zc = '0;
    else if (q_r[CORDIC_STEPS].ax_zero) zc = ANG_HALF_PI;
    zf = zc;
    if (q_r[CORDIC_STEPS].x_neg) zf = ANG_PI - zf;
    if (q_r[CORDIC_STEPS].y_neg) zf = -zf;
    if (q_r[CORDIC_STEPS].both_zero) zf = '0;
  end

  always_ff @(posedge clk) begin
    if (en) angle_r <= 19'(zf);
  end

  assign angle = angle_r;

endmodule

// File: design/vuc_isqrt.sv
module vuc_isqrt
  import vuc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] radicand,
  output logic [15:0] root
);

  logic [32:0] v_r [SQRT_STEPS+1];
  logic [32:0] r_r [SQRT_STEPS+1];
  logic [15:0] d_r [SQRT_PAD+1];

  assign v_r[0] = 33'(radicand);
  assign r_r[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_digit
    localparam logic [32:0] BIT = 33'(1) << (30 - 2 * i);
    logic [32:0] t;
    assign t = r_r[i] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_r[i] >= t) begin
          v_r[i+1] <= v_r[i] - t;
          r_r[i+1] <= (r_r[i] >> 1) + BIT;
        end else begin
          v_r[i+1] <= v_r[i];
          r_r[i+1] <= r_r[i] >> 1;
        end
      end
    end
  end

  // round to nearest, then pad to the angle unit's latency
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= (v_r[SQRT_STEPS] > r_r[SQRT_STEPS]) ? 16'(r_r[SQRT_STEPS] + 33'd1)
                                                    : 16'(r_r[SQRT_STEPS]);
    end
  end

  for (genvar j = 0; j < SQRT_PAD; j++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) d_r[j+1] <= d_r[j];
    end
  end

  assign root = d_r[SQRT_PAD];

endmodule

// File: design/vuc_checker.sv
module vuc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_pready
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:38] == 2'b00 && cfg_pready)
    else $error("pad bits set or register port not ready");

endmodule

bind velocity_to_unicycle_command_core vuc_checker u_vuc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
